[src/dbrv_pkg.sv]
// Shared widths, constants and types for the discounted backup variance block.
`timescale 1ns / 1ps
`default_nettype none
package dbrv_pkg;
   localparam int OBS_SLOTS_DEF = 4096;
   localparam int IDX_W = 12;
   localparam int CNT_W = 16;
   localparam int VAL_W = 32;
   localparam int DISC_W = 17;
   localparam logic [DISC_W-1:0] DISC_RESET = 17'd65536;
   localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

   // Division request and answer between the sequencer and the divider.
   typedef struct packed {
      logic        go;
      logic [64:0] dividend;  // signed
      logic [16:0] divisor;   // 1..65536
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [64:0] quotient;  // signed, truncated toward zero
   } div_rsp_type;
endpackage
`default_nettype wire

[src/dbrv_div.sv]
// Radix-2 restoring divider, signed dividend, truncating toward zero.
`timescale 1ns / 1ps
`default_nettype none
module dbrv_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dbrv_pkg::div_req_type req,
   output dbrv_pkg::div_rsp_type   rsp
);
   logic [63:0] quo_ff, quo_in;
   logic [17:0] rem_ff, rem_in;
   logic [16:0] dvs_ff, dvs_in;
   logic        neg_ff, neg_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [17:0] trial;
   logic [18:0] diff;
   logic [63:0] mag;

   // One quotient bit per cycle, 64 quotient bits in all.
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      mag = req.dividend[64] ? 64'(-req.dividend) : req.dividend[63:0];
      trial = {rem_ff[16:0], quo_ff[63]};
      diff = {1'b0, trial} - {2'b00, dvs_ff};
      if (req.go) begin
         quo_in = mag;
         rem_in = '0;
         dvs_in = req.divisor;
         neg_in = req.dividend[64];
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[18]) begin
            rem_in = diff[17:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quotient = neg_ff ? -{1'b0, quo_ff} : {1'b0, quo_ff};
endmodule
`default_nettype wire

[src/dbrv_mem.sv]
// Slot table: count, mean and variance in one synchronous memory.
`timescale 1ns / 1ps
`default_nettype none
module dbrv_mem #(
   parameter int OBS_SLOTS = dbrv_pkg::OBS_SLOTS_DEF,
   parameter int AW = $clog2(OBS_SLOTS)
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic [79:0]        rd_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [79:0]   wr_data
);
   logic [79:0] mem [OBS_SLOTS];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

[src/discounted_backup_running_variance.sv]
// Top level: sequencer for the discounted backup with Welford slot update.
//
//   channel | direction | handshake           | word
//   req_    | in        | start, busy         | trace node
//   rsp_    | out       | rsp_valid strobe    | slot update
//   csr_    | in        | csr_valid/csr_ready | discount
//
// A visited slot holds busy through the slot read, the count check, the first
// divider pass, the second difference, the multiply and the second divider
// pass (each pass gives 64 quotient bits and then the done cycle), and then
// the count update, the write back and the return update.
// An unvisited slot skips the divider and the steps between them.
// The result strobe comes on the last busy cycle; the next word can be taken
// on the cycle after it.
// After reset a clearing pass zeroes all OBS_SLOTS entries, one a cycle,
// with busy held high. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module discounted_backup_running_variance #(
   parameter int OBS_SLOTS = dbrv_pkg::OBS_SLOTS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_start_of_trace,
   input  wire logic [31:0] req_leaf_value,
   input  wire logic [31:0] req_leaf_variance,
   input  wire logic [11:0] req_obs_index,
   input  wire logic [31:0] req_node_score,
   output logic             rsp_valid,
   output logic [11:0]      rsp_slot_index,
   output logic [15:0]      rsp_new_count,
   output logic [31:0]      rsp_new_mean,
   output logic [31:0]      rsp_new_variance,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [16:0] csr_data
);
   localparam int AW = (OBS_SLOTS > 1) ? $clog2(OBS_SLOTS) : 1;

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_READ  = 4'd2;
   localparam logic [3:0] ST_EVAL  = 4'd3;
   localparam logic [3:0] ST_DIV1  = 4'd4;
   localparam logic [3:0] ST_D2    = 4'd5;
   localparam logic [3:0] ST_MUL   = 4'd6;
   localparam logic [3:0] ST_DIV2  = 4'd7;
   localparam logic [3:0] ST_WRITE = 4'd8;
   localparam logic [3:0] ST_SCALE = 4'd9;
   localparam logic [3:0] ST_RET   = 4'd10;

   logic [3:0]  state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [16:0] disc_ff;
   logic signed [31:0] ret_ff, ret_in;
   logic [31:0] hvar_ff, hvar_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic signed [31:0] score_ff, score_in;
   logic signed [31:0] r_ff, r_in;
   logic [15:0] cnt_ff, cnt_in;
   logic signed [31:0] omean_ff, omean_in;
   logic [31:0] ovar_ff, ovar_in;
   logic signed [32:0] d1_ff, d1_in;
   logic signed [32:0] d2_ff, d2_in;
   logic signed [31:0] mean_ff, mean_in;
   logic [31:0] var_ff, var_in;
   logic [63:0] prod_ff, prod_in;
   logic signed [49:0] scl_ff, scl_in;
   logic        vld_ff, vld_in;

   logic        rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [79:0] rd_data, wr_data;
   dbrv_pkg::div_req_type dreq;
   dbrv_pkg::div_rsp_type drsp;

   logic [32:0] m1, m2;
   logic signed [66:0] vsum;
   logic signed [32:0] rsum;
   logic signed [32:0] msum;
   logic signed [33:0] scl_sat;
   logic [AW-1:0] slot_req;

   function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
      if (v > 51'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -51'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   dbrv_mem #(.OBS_SLOTS(OBS_SLOTS), .AW(AW)) u_mem (
      .clock(clock), .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
   );

   dbrv_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // Slot reduction by restoring compare and subtract against the depth
   // shifted down one bit per step; steps whose shifted depth is at least
   // 4096 can never subtract and drop out.
   always_comb begin
      logic [12:0] v;
      v = {1'b0, req_obs_index};
      for (int k = 11; k >= 0; k--) begin
         if ((64'(OBS_SLOTS) << k) < 64'd4096) begin
            if (v >= 13'(64'(OBS_SLOTS) << k)) v = v - 13'(64'(OBS_SLOTS) << k);
         end
      end
      slot_req = AW'(v);
   end

   assign busy = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      ret_in = ret_ff;
      hvar_in = hvar_ff;
      slot_in = slot_ff;
      score_in = score_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      omean_in = omean_ff;
      ovar_in = ovar_ff;
      d1_in = d1_ff;
      d2_in = d2_ff;
      mean_in = mean_ff;
      var_in = var_ff;
      prod_in = prod_ff;
      scl_in = scl_ff;
      vld_in = 1'b0;
      rd_en = 1'b0;
      rd_addr = slot_ff;
      wr_en = 1'b0;
      wr_addr = slot_ff;
      wr_data = {cnt_ff, mean_ff, var_ff};
      dreq.go = 1'b0;
      dreq.dividend = 65'(d1_ff);
      dreq.divisor = 17'(cnt_ff) + 17'd1;
      m1 = d1_ff[32] ? 33'(-d1_ff) : d1_ff;
      m2 = d2_ff[32] ? 33'(-d2_ff) : d2_ff;
      vsum = 67'(signed'({1'b0, ovar_ff})) + 67'(signed'(drsp.quotient));
      rsum = 33'(ret_ff) - 33'(score_ff);
      msum = 33'(omean_ff) + drsp.quotient[32:0];
      scl_sat = 34'(sat32(51'(scl_ff)));
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(OBS_SLOTS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               if (req_start_of_trace) begin
                  ret_in = req_leaf_value;
                  hvar_in = req_leaf_variance;
               end
               slot_in = slot_req;
               score_in = req_node_score;
               rd_en = 1'b1;
               rd_addr = slot_req;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            r_in = sat32(51'(rsum));
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cnt_in = rd_data[79:64];
            omean_in = rd_data[63:32];
            ovar_in = rd_data[31:0];
            d1_in = 33'(r_ff) - 33'(signed'(rd_data[63:32]));
            if (rd_data[79:64] == 16'd0) begin
               mean_in = r_ff;
               var_in = hvar_ff;
               state_in = ST_WRITE;
            end else begin
               state_in = ST_DIV1;
               dreq.go = 1'b1;
               dreq.dividend = 65'(33'(r_ff) - 33'(signed'(rd_data[63:32])));
               dreq.divisor = 17'(rd_data[79:64]) + 17'd1;
            end
         end
         ST_DIV1: begin
            if (drsp.done) begin
               mean_in = msum[31:0];
               state_in = ST_D2;
            end
         end
         ST_D2: begin
            d2_in = 33'(r_ff) - 33'(mean_ff);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in = 64'((66'(m1) * 66'(m2)) >> 16);
            state_in = ST_DIV2;
            dreq.go = 1'b1;
            dreq.dividend = 65'(signed'({1'b0, 64'((66'(m1) * 66'(m2)) >> 16)}))
                            - 65'(signed'({1'b0, ovar_ff}));
         end
         ST_DIV2: begin
            if (drsp.done) begin
               if (vsum < 0) var_in = '0;
               else if (vsum > 67'sd4294967295) var_in = 32'hFFFFFFFF;
               else var_in = vsum[31:0];
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (cnt_ff != dbrv_pkg::CNT_MAX) cnt_in = cnt_ff + 16'd1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            wr_en = 1'b1;
            vld_in = 1'b1;
            scl_in = 50'(($signed({1'b0, disc_ff}) * r_ff) / 65536);
            state_in = ST_RET;
         end
         ST_RET: begin
            ret_in = sat32(51'(scl_sat) + 51'(score_ff));
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         disc_ff <= dbrv_pkg::DISC_RESET;
         ret_ff <= '0;
         hvar_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         if (csr_valid && csr_ready) disc_ff <= csr_data;
         ret_ff <= ret_in;
         hvar_ff <= hvar_in;
         vld_ff <= vld_in;
      end
      slot_ff <= slot_in;
      score_ff <= score_in;
      r_ff <= r_in;
      cnt_ff <= cnt_in;
      omean_ff <= omean_in;
      ovar_ff <= ovar_in;
      d1_ff <= d1_in;
      d2_ff <= d2_in;
      mean_ff <= mean_in;
      var_ff <= var_in;
      prod_ff <= prod_in;
      scl_ff <= scl_in;
   end

   // Result word registered on the write-back cycle.
   logic [11:0] oslot_ff;
   logic [15:0] ocnt_ff;
   logic [31:0] omn_ff, ovr_ff;
   always_ff @(posedge clock) begin
      if (vld_in) begin
         oslot_ff <= 12'(slot_ff);
         ocnt_ff <= cnt_ff;
         omn_ff <= mean_ff;
         ovr_ff <= var_ff;
      end
   end
   assign rsp_valid = vld_ff;
   assign rsp_slot_index = oslot_ff;
   assign rsp_new_count = ocnt_ff;
   assign rsp_new_mean = omn_ff;
   assign rsp_new_variance = ovr_ff;
endmodule
`default_nettype wire

[src/dbrv_checker.sv]
// Port checker for the discounted backup variance block, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module dbrv_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid,
   input wire logic [15:0] rsp_new_count
);
   // An accepted word makes the block busy next cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy did not rise");
   // Results are single-cycle strobes.
   a_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result held twice");
   // A result never shows a zero count.
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_new_count != 16'd0) else $error("zero count");
   // No result while idle without an item in flight.
   a_idle: assert property (@(posedge clock) disable iff (reset)
      !$past(busy) && !busy |-> !rsp_valid) else $error("spurious result");
endmodule

bind discounted_backup_running_variance dbrv_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_new_count(rsp_new_count)
);
`default_nettype wire
